>>> rtl/directional_curvature_gradient_fit_top_defines.svh
// Assertion macros for the checker file of the curvature gradient fit block.
`ifndef DIRECTIONAL_CURVATURE_GRADIENT_FIT_TOP_DEFINES_SVH
`define DIRECTIONAL_CURVATURE_GRADIENT_FIT_TOP_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define DCGF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define DCGF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/dcgf_pkg.sv
// Types and constants shared by the curvature gradient fit modules.
`default_nettype none
package dcgf_pkg;

   localparam int CNT_W = 9;
   localparam int MUL_STEPS = 48;
   localparam int DIV_STEPS = 34;
   localparam logic [95:0] DET_EPS = 96'd4294967;

   typedef enum logic [2:0] {
      CMD_CENTER   = 3'd0,
      CMD_MAJOR    = 3'd1,
      CMD_MINOR    = 3'd2,
      CMD_NEIGHBOR = 3'd3,
      CMD_FINISH   = 3'd4
   } cmd_type;

   localparam logic [1:0] STATUS_FIT      = 2'd0;
   localparam logic [1:0] STATUS_SKIP     = 2'd1;
   localparam logic [1:0] STATUS_SINGULAR = 2'd2;

   localparam logic [1:0] CSR_NBR_TARGET   = 2'd0;
   localparam logic [1:0] CSR_RADIUS       = 2'd1;
   localparam logic [1:0] CSR_OFFSET_SCALE = 2'd2;

   typedef struct packed {
      cmd_type            cmd;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      logic signed [31:0] cmaj;
      logic signed [31:0] cmin;
   } item_type;

   typedef struct packed {
      logic [CNT_W-1:0]   count;
      logic signed [47:0] so;
      logic signed [63:0] soo;
      logic signed [47:0] sc;
      logic signed [63:0] soc;
   } dir_sums_type;

endpackage
`default_nettype wire

>>> rtl/dcgf_channels.sv
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none
interface dcgf_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         command;
   logic signed [31:0] vec_x;
   logic signed [31:0] vec_y;
   logic signed [31:0] vec_z;
   logic signed [31:0] curv_major;
   logic signed [31:0] curv_minor;
   modport source (output valid, command, vec_x, vec_y, vec_z, curv_major, curv_minor,
                   input ready);
   modport sink (input valid, command, vec_x, vec_y, vec_z, curv_major, curv_minor,
                 output ready);
endinterface

interface dcgf_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] grad_major;
   logic signed [31:0] grad_minor;
   logic               flip_axes;
   modport source (output valid, status, grad_major, grad_minor, flip_axes, input ready);
   modport sink (input valid, status, grad_major, grad_minor, flip_axes, output ready);
endinterface
`default_nettype wire

>>> rtl/dcgf_front.sv
// Front end: takes request beats, drops unknown commands and queues the rest.
`default_nettype none
module dcgf_front import dcgf_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   dcgf_req_if.sink    req_ch,
   input  wire logic   pop,
   output logic        head_valid,
   output item_type    head
);
   localparam int DEPTH = 2;
   localparam int PW = $clog2(DEPTH);

   item_type         mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]      cnt_ff, cnt_in;
   logic             known, push;
   item_type         beat;

   always_comb begin
      case (cmd_type'(req_ch.command))
         CMD_CENTER, CMD_MAJOR, CMD_MINOR, CMD_NEIGHBOR, CMD_FINISH: known = 1'b1;
         default: known = 1'b0;
      endcase
   end

   assign req_ch.ready = (cnt_ff < (PW+1)'(DEPTH));
   assign push = req_ch.valid && req_ch.ready && known;
   assign beat = '{cmd: cmd_type'(req_ch.command), vx: req_ch.vec_x, vy: req_ch.vec_y,
                   vz: req_ch.vec_z, cmaj: req_ch.curv_major, cmin: req_ch.curv_minor};
   assign head_valid = (cnt_ff != '0);
   assign head = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= beat;
      end
   end
endmodule
`default_nettype wire

>>> rtl/dcgf_accum.sv
// Back end for point, axis and neighbor commands: projections and fit sums.
`default_nettype none
module dcgf_accum import dcgf_pkg::*; #(
   parameter int MAX_FIT_POINTS = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  item_type           item,
   input  wire logic [30:0]   radius,
   input  wire logic [15:0]   offset_scale,
   output logic               busy,
   output dir_sums_type [1:0] sums,
   output logic [CNT_W-1:0]   nbr_count
);
   logic signed [31:0] center_ff [3], center_in [3];
   logic signed [31:0] major_ff [3], major_in [3];
   logic signed [31:0] minor_ff [3], minor_in [3];
   logic signed [32:0] d_ff [3], d_in [3];
   logic signed [31:0] cmaj_ff, cmaj_in, cmin_ff, cmin_in;
   logic               run_ff, run_in, dir_ff, dir_in, ok_ff, ok_in;
   logic [3:0]         step_ff, step_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [56:0] prodb_ff, prodb_in;
   logic signed [50:0] pm_ff, pm_in, pn_ff, pn_in;
   logic signed [31:0] o_ff, o_in;
   dir_sums_type       sums_ff [2], sums_in [2];
   logic [CNT_W-1:0]   nbr_ff, nbr_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [49:0] prod_q;
   logic signed [50:0] own, orth;
   logic [50:0]        orth_abs;
   logic signed [39:0] own_cl;
   logic signed [48:0] ob;
   logic signed [31:0] cdir;

   assign busy = run_ff;
   assign sums[0] = sums_ff[0];
   assign sums[1] = sums_ff[1];
   assign nbr_count = nbr_ff;

   assign prod_q = prod_ff[65:16];
   assign own = dir_ff ? pn_ff : pm_ff;
   assign orth = dir_ff ? pm_ff : pn_ff;
   assign orth_abs = orth[50] ? 51'(-orth) : 51'(orth);
   assign cdir = dir_ff ? cmin_ff : cmaj_ff;
   assign ob = prodb_ff[56:8];

   // Projections are clamped to 40 bits: anything larger saturates the offset anyway.
   always_comb begin
      if (!own[50] && (own[50:39] != '0)) begin
         own_cl = {1'b0, {39{1'b1}}};
      end else if (own[50] && (own[50:39] != '1)) begin
         own_cl = {1'b1, {39{1'b0}}};
      end else begin
         own_cl = own[39:0];
      end
   end

   always_comb begin
      case (step_ff)
         4'd0: begin mul_a = 33'(major_ff[0]); mul_b = d_ff[0]; end
         4'd1: begin mul_a = 33'(major_ff[1]); mul_b = d_ff[1]; end
         4'd2: begin mul_a = 33'(major_ff[2]); mul_b = d_ff[2]; end
         4'd3: begin mul_a = 33'(minor_ff[0]); mul_b = d_ff[0]; end
         4'd4: begin mul_a = 33'(minor_ff[1]); mul_b = d_ff[1]; end
         4'd5: begin mul_a = 33'(minor_ff[2]); mul_b = d_ff[2]; end
         4'd9: begin mul_a = 33'(o_ff); mul_b = 33'(o_ff); end
         4'd10: begin mul_a = 33'(o_ff); mul_b = 33'(cdir); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign prodb_in = own_cl * $signed({1'b0, offset_scale});

   always_comb begin
      center_in = center_ff;
      major_in = major_ff;
      minor_in = minor_ff;
      d_in = d_ff;
      cmaj_in = cmaj_ff;
      cmin_in = cmin_ff;
      run_in = run_ff;
      dir_in = dir_ff;
      ok_in = ok_ff;
      step_in = step_ff;
      pm_in = pm_ff;
      pn_in = pn_ff;
      o_in = o_ff;
      sums_in = sums_ff;
      nbr_in = nbr_ff;
      if (start && !run_ff) begin
         case (item.cmd)
            CMD_CENTER: begin
               center_in = '{item.vx, item.vy, item.vz};
               sums_in = '{default: '0};
               nbr_in = '0;
            end
            CMD_MAJOR: major_in = '{item.vx, item.vy, item.vz};
            CMD_MINOR: minor_in = '{item.vx, item.vy, item.vz};
            CMD_NEIGHBOR: begin
               d_in[0] = 33'(item.vx) - 33'(center_ff[0]);
               d_in[1] = 33'(item.vy) - 33'(center_ff[1]);
               d_in[2] = 33'(item.vz) - 33'(center_ff[2]);
               cmaj_in = item.cmaj;
               cmin_in = item.cmin;
               if (nbr_ff != '1) begin
                  nbr_in = nbr_ff + 1'b1;
               end
               pm_in = '0;
               pn_in = '0;
               dir_in = 1'b0;
               step_in = '0;
               run_in = 1'b1;
            end
            default: ;
         endcase
      end else if (run_ff) begin
         step_in = step_ff + 1'b1;
         case (step_ff)
            4'd1, 4'd2, 4'd3: pm_in = pm_ff + 51'(prod_q);
            4'd4, 4'd5, 4'd6: pn_in = pn_ff + 51'(prod_q);
            4'd7: ok_in = (sums_ff[dir_ff].count < CNT_W'(MAX_FIT_POINTS)) &&
                          ({orth_abs, 1'b0} <= 52'(radius));
            4'd8: begin
               if (!ob[48] && (ob[48:31] != '0)) begin
                  o_in = 32'sh7FFF_FFFF;
               end else if (ob[48] && (ob[48:31] != '1)) begin
                  o_in = 32'sh8000_0000;
               end else begin
                  o_in = ob[31:0];
               end
            end
            4'd10: begin
               if (ok_ff) begin
                  sums_in[dir_ff].soo = sums_ff[dir_ff].soo + 64'(prod_q);
               end
            end
            4'd11: begin
               if (ok_ff) begin
                  sums_in[dir_ff].soc = sums_ff[dir_ff].soc + 64'(prod_q);
                  sums_in[dir_ff].so = sums_ff[dir_ff].so + 48'(o_ff);
                  sums_in[dir_ff].sc = sums_ff[dir_ff].sc + 48'(cdir);
                  sums_in[dir_ff].count = sums_ff[dir_ff].count + 1'b1;
               end
               if (!dir_ff) begin
                  dir_in = 1'b1;
                  step_in = 4'd7;
               end else begin
                  run_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '{default: '0};
         major_ff <= '{default: '0};
         minor_ff <= '{default: '0};
         sums_ff <= '{default: '0};
         nbr_ff <= '0;
         run_ff <= 1'b0;
         step_ff <= '0;
         dir_ff <= 1'b0;
      end else begin
         center_ff <= center_in;
         major_ff <= major_in;
         minor_ff <= minor_in;
         sums_ff <= sums_in;
         nbr_ff <= nbr_in;
         run_ff <= run_in;
         step_ff <= step_in;
         dir_ff <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in;
      cmaj_ff <= cmaj_in;
      cmin_ff <= cmin_in;
      ok_ff <= ok_in;
      pm_ff <= pm_in;
      pn_ff <= pn_in;
      o_ff <= o_in;
      prod_ff <= prod_in;
      prodb_ff <= prodb_in;
   end
endmodule
`default_nettype wire

>>> rtl/dcgf_solve.sv
// Back end for the finish command: least-squares slopes and the response register.
`default_nettype none
module dcgf_solve import dcgf_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  dir_sums_type [1:0] sums,
   input  wire logic [CNT_W-1:0] nbr_count,
   input  wire logic [8:0]    nbr_target,
   output logic               busy,
   dcgf_rsp_if.source         rsp_ch
);
   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_LOAD = 7'b0000010,
      S_MUL  = 7'b0000100,
      S_CALC = 7'b0001000,
      S_PREP = 7'b0010000,
      S_DIV  = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic               dir_ff, dir_in, nso_ff, nso_in, qneg_ff, qneg_in;
   logic signed [73:0] t1_ff, t1_in, t2_ff, t2_in;
   logic signed [95:0] a1_ff, a1_in, a2_ff, a2_in, acc1_ff, acc1_in, acc2_ff, acc2_in;
   logic signed [95:0] det_ff, det_in, num_ff, num_in;
   logic [47:0]        b_ff, b_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [111:0]       rem_ff, rem_in;
   logic [128:0]       dsh_ff, dsh_in;
   logic [33:0]        q_ff, q_in;
   logic signed [31:0] gmaj_ff, gmaj_in, gmin_ff, gmin_in, slope;
   logic [1:0]         st_ff, st_in;
   logic               vld_ff, vld_in;
   logic [1:0]         ost_ff, ost_in;
   logic signed [31:0] ogmaj_ff, ogmaj_in, ogmin_ff, ogmin_in;
   logic               oflip_ff, oflip_in;

   dir_sums_type       s;
   logic signed [95:0] ss, sc;
   logic [95:0]        adet, anum;
   logic               qbit, load_out;

   assign busy = (state_ff != S_IDLE);
   assign s = sums[dir_ff];
   assign ss = nso_ff ? -acc1_ff : acc1_ff;
   assign sc = nso_ff ? -acc2_ff : acc2_ff;
   assign adet = det_ff[95] ? 96'(-det_ff) : 96'(det_ff);
   assign anum = num_ff[95] ? 96'(-num_ff) : 96'(num_ff);
   assign qbit = ({17'b0, rem_ff} >= dsh_ff);
   assign q_in = {q_ff[32:0], qbit};
   assign load_out = (state_ff == S_OUT) && (!vld_ff || rsp_ch.ready);

   always_comb begin
      if (qneg_ff) begin
         slope = (q_in > 34'h0_8000_0000) ? 32'sh8000_0000 : -$signed(q_in[31:0]);
      end else begin
         slope = (q_in > 34'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q_in[31:0]);
      end
   end

   always_comb begin
      state_in = state_ff;
      dir_in = dir_ff;
      nso_in = nso_ff;
      qneg_in = qneg_ff;
      t1_in = t1_ff;
      t2_in = t2_ff;
      a1_in = a1_ff;
      a2_in = a2_ff;
      acc1_in = acc1_ff;
      acc2_in = acc2_ff;
      det_in = det_ff;
      num_in = num_ff;
      b_in = b_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      gmaj_in = gmaj_ff;
      gmin_in = gmin_ff;
      st_in = st_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               dir_in = 1'b0;
               if (nbr_count < {1'b0, nbr_target[8:1]}) begin
                  st_in = STATUS_SKIP;
                  state_in = S_OUT;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            t1_in = $signed({1'b0, s.count}) * s.soo;
            t2_in = $signed({1'b0, s.count}) * s.soc;
            nso_in = s.so[47];
            b_in = s.so[47] ? 48'(-s.so) : 48'(s.so);
            a1_in = 96'(s.so);
            a2_in = 96'(s.sc);
            acc1_in = '0;
            acc2_in = '0;
            cnt_in = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            // Shift-and-add over the magnitude of the offset sum, one bit a cycle.
            if (b_ff[0]) begin
               acc1_in = acc1_ff + a1_ff;
               acc2_in = acc2_ff + a2_ff;
            end
            a1_in = a1_ff <<< 1;
            a2_in = a2_ff <<< 1;
            b_in = b_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(MUL_STEPS - 1)) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            det_in = $signed({{6{t1_ff[73]}}, t1_ff, 16'b0}) - ss;
            num_in = $signed({{6{t2_ff[73]}}, t2_ff, 16'b0}) - sc;
            state_in = S_PREP;
         end
         S_PREP: begin
            if (adet <= DET_EPS) begin
               st_in = STATUS_SINGULAR;
               state_in = S_OUT;
            end else begin
               rem_in = {anum, 16'b0};
               dsh_in = {adet, 33'b0};
               qneg_in = num_ff[95] ^ det_ff[95];
               cnt_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // Restoring division; a quotient of 2^31 or more saturates either way.
            if (qbit) begin
               rem_in = rem_ff - dsh_ff[111:0];
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               if (!dir_ff) begin
                  gmaj_in = slope;
                  dir_in = 1'b1;
                  state_in = S_LOAD;
               end else begin
                  gmin_in = slope;
                  st_in = STATUS_FIT;
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      vld_in = vld_ff;
      ost_in = ost_ff;
      ogmaj_in = ogmaj_ff;
      ogmin_in = ogmin_ff;
      oflip_in = oflip_ff;
      if (vld_ff && rsp_ch.ready) begin
         vld_in = 1'b0;
      end
      if (load_out) begin
         vld_in = 1'b1;
         ost_in = st_ff;
         ogmaj_in = (st_ff == STATUS_FIT) ? gmaj_ff : '0;
         ogmin_in = (st_ff == STATUS_FIT) ? gmin_ff : '0;
         oflip_in = (st_ff == STATUS_FIT) && gmaj_ff[31];
      end
   end

   assign rsp_ch.valid = vld_ff;
   assign rsp_ch.status = ost_ff;
   assign rsp_ch.grad_major = ogmaj_ff;
   assign rsp_ch.grad_minor = ogmin_ff;
   assign rsp_ch.flip_axes = oflip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff <= 1'b0;
         dir_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
         dir_ff <= dir_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      nso_ff <= nso_in;
      qneg_ff <= qneg_in;
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      a1_ff <= a1_in;
      a2_ff <= a2_in;
      acc1_ff <= acc1_in;
      acc2_ff <= acc2_in;
      det_ff <= det_in;
      num_ff <= num_in;
      b_ff <= b_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff <= (state_ff == S_DIV) ? q_in : '0;
      gmaj_ff <= gmaj_in;
      gmin_ff <= gmin_in;
      st_ff <= st_in;
      ost_ff <= ost_in;
      ogmaj_ff <= ogmaj_in;
      ogmin_ff <= ogmin_in;
      oflip_ff <= oflip_in;
   end
endmodule
`default_nettype wire

>>> rtl/directional_curvature_gradient_fit_top.sv
// Usage: a command stream (center point, major axis, minor axis, neighbors, finish)
// enters on req_ch; each finish beat yields one response beat on rsp_ch with the
// status, both slopes and the axis-flip flag. Other commands give no response.
// Beats are queued in a two-entry front queue; commands 5 to 7 are dropped there.
// At the back end a neighbor uses one shared 33x33 multiplier for the six
// projection products and the two fit products per direction, and a separate
// multiplier for the offset scaling; a full fit uses, per direction, a
// shift-add multiplier and a restoring divider.
// Reset (synchronous, active high) clears the held point, axes, counts and
// sums, loads the registers with their defaults and empties the queue.
// When rsp_ch stalls, the response holds in its output register; the back end
// keeps working on later commands until a second finish needs that register.
// Configuration is written through csr_we/csr_index/csr_wdata; the user must
// write it only while idle, which the block itself does not enforce.
`default_nettype none
module directional_curvature_gradient_fit_top import dcgf_pkg::*; #(
   parameter int MAX_FIT_POINTS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   dcgf_req_if.sink         req_ch,
   dcgf_rsp_if.source       rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [30:0] csr_wdata
);
   logic [8:0]         maxnb_ff, maxnb_in;
   logic [30:0]        radius_ff, radius_in;
   logic [15:0]        scale_ff, scale_in;
   logic               head_valid, pop, acc_busy, solve_busy;
   item_type           head;
   dir_sums_type [1:0] sums;
   logic [CNT_W-1:0]   nbr_count;

   always_comb begin
      maxnb_in = maxnb_ff;
      radius_in = radius_ff;
      scale_in = scale_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_NBR_TARGET: maxnb_in = csr_wdata[8:0];
            CSR_RADIUS: radius_in = csr_wdata;
            CSR_OFFSET_SCALE: scale_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         maxnb_ff <= 9'd32;
         radius_ff <= 31'd65536;
         scale_ff <= 16'd256;
      end else begin
         maxnb_ff <= maxnb_in;
         radius_ff <= radius_in;
         scale_ff <= scale_in;
      end
   end

   // The back end takes one command at a time, in order.
   assign pop = head_valid && !acc_busy && !solve_busy;

   dcgf_front u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch),
      .pop(pop), .head_valid(head_valid), .head(head)
   );

   dcgf_accum #(.MAX_FIT_POINTS(MAX_FIT_POINTS)) u_accum (
      .clock(clock), .reset(reset),
      .start(pop && (head.cmd != CMD_FINISH)), .item(head),
      .radius(radius_ff), .offset_scale(scale_ff),
      .busy(acc_busy), .sums(sums), .nbr_count(nbr_count)
   );

   dcgf_solve u_solve (
      .clock(clock), .reset(reset),
      .start(pop && (head.cmd == CMD_FINISH)),
      .sums(sums), .nbr_count(nbr_count), .nbr_target(maxnb_ff),
      .busy(solve_busy), .rsp_ch(rsp_ch)
   );
endmodule
`default_nettype wire

>>> rtl/dcgf_checker.sv
// Port-level assertions for the curvature gradient fit top level, with its bind.
`default_nettype none
`include "directional_curvature_gradient_fit_top_defines.svh"
module dcgf_checker import dcgf_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  status,
   input wire logic [31:0] grad_major,
   input wire logic [31:0] grad_minor,
   input wire logic        flip_axes
);
   // A stalled response beat keeps its status and both slopes.
   `DCGF_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(grad_major) && $stable(grad_minor), "response changed while stalled")
   `DCGF_ASSERT(a_status_code, rsp_valid |-> status == STATUS_FIT || status == STATUS_SKIP || status == STATUS_SINGULAR, "undefined status code")
   `DCGF_ASSERT(a_zero_unfit, rsp_valid && status != STATUS_FIT |-> grad_major == '0 && grad_minor == '0 && !flip_axes, "nonzero slope without a fit")
   `DCGF_ASSERT(a_flip_sign, rsp_valid && flip_axes |-> grad_major[31] && status == STATUS_FIT, "flip flag disagrees with slope sign")
   `DCGF_ASSERT_ALWAYS(a_reset_clear, reset |=> !rsp_valid, "response valid after reset")
endmodule

bind directional_curvature_gradient_fit_top dcgf_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .status(rsp_ch.status),
   .grad_major(rsp_ch.grad_major), .grad_minor(rsp_ch.grad_minor),
   .flip_axes(rsp_ch.flip_axes)
);
`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the directional curvature gradient fit block.
`default_nettype none
module testbench;
   import dcgf_pkg::*;

   localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
   localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;
   localparam int FIT_LIMIT = 32;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 250;
   localparam int WATCHDOG_LIMIT = 6000;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] gmaj;
      logic signed [31:0] gmin;
      logic               flip;
   } slope_result_type;

   // Predicts the slopes from the accepted beats and checks every response beat.
   class slope_scoreboard;
      longint cen[3], maj[3], mnr[3];
      int unsigned nbr_cnt;
      int unsigned fcnt[2];
      longint so[2], soo[2], sc[2], soc[2];
      int unsigned max_nbr, radius, scale;
      slope_result_type slopes_due[$];
      int errors;
      int results_seen;
      int skips, singulars, fits, flips;

      function new();
         for (int k = 0; k < 3; k++) begin
            cen[k] = 0; maj[k] = 0; mnr[k] = 0;
         end
         clear_sums();
         max_nbr = 32; radius = 65536; scale = 256;
         errors = 0; results_seen = 0;
         skips = 0; singulars = 0; fits = 0; flips = 0;
      endfunction

      function void clear_sums();
         nbr_cnt = 0;
         for (int i = 0; i < 2; i++) begin
            fcnt[i] = 0; so[i] = 0; soo[i] = 0; sc[i] = 0; soc[i] = 0;
         end
      endfunction

      function void set_reg(logic [1:0] idx, logic [30:0] val);
         if (idx == CSR_NBR_TARGET) max_nbr = val[8:0];
         else if (idx == CSR_RADIUS) radius = val;
         else if (idx == CSR_OFFSET_SCALE) scale = val[15:0];
      endfunction

      function longint dot(longint a[3], longint d[3]);
         logic signed [127:0] pr, t;
         longint s;
         s = 0;
         for (int k = 0; k < 3; k++) begin
            pr = a[k];
            t = d[k];
            pr = pr * t;
            pr = pr >>> 16;
            s += longint'(pr);
         end
         return s;
      endfunction

      function bit fit_dir(int dir, output longint slope);
         logic signed [127:0] n, a, b, det, num;
         logic [127:0] ad, an, q;
         bit neg;
         slope = 0;
         n = fcnt[dir];
         a = soo[dir];
         det = (n * a) <<< 16;
         a = so[dir];
         det = det - a * a;
         b = soc[dir];
         num = (n * b) <<< 16;
         b = sc[dir];
         num = num - a * b;
         ad = det < 0 ? -det : det;
         if (ad <= 128'(DET_EPS)) return 0;
         neg = (num < 0) != (det < 0);
         an = num < 0 ? -num : num;
         q = (an << 16) / ad;
         if (neg) slope = (q > 128'h80000000) ? -longint'(32'h80000000) : -longint'(q[63:0]);
         else slope = (q > 128'h7FFFFFFF) ? longint'(32'h7FFFFFFF) : longint'(q[63:0]);
         return 1;
      endfunction

      function void note_item(item_type it);
         longint v[3], d[3];
         longint op, p, o, c;
         logic signed [127:0] w, x;
         slope_result_type r;
         longint gmaj, gmin;
         v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
         case (it.cmd)
            CMD_CENTER: begin
               for (int k = 0; k < 3; k++) cen[k] = v[k];
               clear_sums();
            end
            CMD_MAJOR: for (int k = 0; k < 3; k++) maj[k] = v[k];
            CMD_MINOR: for (int k = 0; k < 3; k++) mnr[k] = v[k];
            CMD_NEIGHBOR: begin
               for (int k = 0; k < 3; k++) d[k] = v[k] - cen[k];
               if (nbr_cnt < 511) nbr_cnt++;
               for (int dir = 0; dir < 2; dir++) begin
                  if (fcnt[dir] >= FIT_LIMIT) continue;
                  op = dir == 0 ? dot(mnr, d) : dot(maj, d);
                  if (op < 0) op = -op;
                  if (2 * op > longint'(radius)) continue;
                  p = dir == 0 ? dot(maj, d) : dot(mnr, d);
                  if (p > (64'sd1 <<< 47)) p = 64'sd1 <<< 47;
                  if (p < -(64'sd1 <<< 47)) p = -(64'sd1 <<< 47);
                  w = p;
                  x = longint'(scale);
                  w = (w * x) >>> 8;
                  if (w > 128'sh7FFFFFFF) w = 128'sh7FFFFFFF;
                  if (w < -128'sh80000000) w = -128'sh80000000;
                  o = longint'(w);
                  c = dir == 0 ? longint'(it.cmaj) : longint'(it.cmin);
                  fcnt[dir]++;
                  so[dir] += o;
                  w = o;
                  x = o;
                  soo[dir] += longint'((w * x) >>> 16);
                  sc[dir] += c;
                  x = c;
                  soc[dir] += longint'((w * x) >>> 16);
               end
            end
            CMD_FINISH: begin
               r = '0;
               gmaj = 0; gmin = 0;
               if (nbr_cnt < max_nbr / 2) begin
                  r.status = STATUS_SKIP;
               end else if (!fit_dir(0, gmaj) || !fit_dir(1, gmin)) begin
                  r.status = STATUS_SINGULAR;
                  gmaj = 0; gmin = 0;
               end else begin
                  r.status = STATUS_FIT;
                  r.flip = gmaj < 0;
               end
               r.gmaj = gmaj[31:0];
               r.gmin = gmin[31:0];
               slopes_due.push_back(r);
            end
            default: ;
         endcase
      endfunction

      function void check_result(slope_result_type got);
         slope_result_type want;
         results_seen++;
         if (slopes_due.size() == 0) begin
            $display("%0t: response beat with nothing expected: status %0d", $time, got.status);
            errors++;
            return;
         end
         want = slopes_due.pop_front();
         if (want.status == STATUS_SKIP) skips++;
         else if (want.status == STATUS_SINGULAR) singulars++;
         else fits++;
         if (want.flip) flips++;
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.gmaj !== want.gmaj) begin
            $display("%0t: grad_major expected %0d actual %0d", $time, want.gmaj, got.gmaj);
            errors++;
         end
         if (got.gmin !== want.gmin) begin
            $display("%0t: grad_minor expected %0d actual %0d", $time, want.gmin, got.gmin);
            errors++;
         end
         if (got.flip !== want.flip) begin
            $display("%0t: flip_axes expected %0d actual %0d", $time, want.flip, got.flip);
            errors++;
         end
      endfunction

      function int pending();
         return slopes_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [1:0] csr_index;
   logic [30:0] csr_wdata;

   dcgf_req_if req_ch();
   dcgf_rsp_if rsp_ch();

   directional_curvature_gradient_fit_top dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   slope_scoreboard sb = new();
   bit tx_fast;
   bit rx_fast;
   bit hold_req;
   int idle_cycles;
   int items_sent;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   function automatic logic signed [31:0] near(int span);
      return $signed($urandom_range(2 * span)) - span;
   endfunction

   // Response side: random stalls, a long hold-off on request.
   initial begin
      int g;
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ch.ready = 0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 0;
         end else if (rx_fast) begin
            rsp_ch.ready = 1;
         end else begin
            g = pick_gap();
            if (g == 0) begin
               rsp_ch.ready = 1;
            end else begin
               rsp_ch.ready = 0;
               repeat (g - 1) @(negedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      slope_result_type got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status = rsp_ch.status;
            got.gmaj = rsp_ch.grad_major;
            got.gmin = rsp_ch.grad_minor;
            got.flip = rsp_ch.flip_axes;
            sb.check_result(got);
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without a beat", idle_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic send_item(logic [2:0] cmd, logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic signed [31:0] cj,
                            logic signed [31:0] cn);
      item_type it;
      int g;
      req_ch.valid = 1;
      req_ch.command = cmd;
      req_ch.vec_x = x;
      req_ch.vec_y = y;
      req_ch.vec_z = z;
      req_ch.curv_major = cj;
      req_ch.curv_minor = cn;
      do @(posedge clock); while (!req_ch.ready);
      it.cmd = cmd_type'(cmd);
      it.vx = x; it.vy = y; it.vz = z; it.cmaj = cj; it.cmin = cn;
      sb.note_item(it);
      items_sent++;
      @(negedge clock);
      g = tx_fast ? 0 : pick_gap();
      if (g > 0) begin
         req_ch.valid = 0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_ch.valid = 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [30:0] val);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
      sb.set_reg(idx, val);
   endtask

   task automatic set_config(logic [30:0] mn, logic [30:0] rad, logic [30:0] sc);
      drain();
      write_csr(CSR_NBR_TARGET, mn);
      write_csr(CSR_RADIUS, rad);
      write_csr(CSR_OFFSET_SCALE, sc);
   endtask

   // One point: center, axes, some neighbors, a finish. Wide mode uses full-range values.
   task automatic run_point(int n_nb, bit wide);
      logic signed [31:0] cx, cy, cz;
      cx = wide ? $signed($urandom) : near(1 << 22);
      cy = wide ? $signed($urandom) : near(1 << 22);
      cz = wide ? $signed($urandom) : near(1 << 22);
      send_item(CMD_CENTER, cx, cy, cz, $urandom, $urandom);
      if (wide)
         send_item(CMD_MAJOR, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
         send_item(CMD_MAJOR, near(70000), near(70000), near(20000), $urandom, $urandom);
      if (wide)
         send_item(CMD_MINOR, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
         send_item(CMD_MINOR, near(20000), near(70000), near(70000), $urandom, $urandom);
      for (int i = 0; i < n_nb; i++) begin
         if (wide)
            send_item(CMD_NEIGHBOR, $urandom, $urandom, $urandom, $urandom, $urandom);
         else
            send_item(CMD_NEIGHBOR, cx + near(1 << 18), cy + near(1 << 18),
                      cz + near(1 << 18), near(1 << 20), near(1 << 20));
      end
      send_item(CMD_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic run_random(int budget);
      int r;
      int start;
      start = items_sent;
      while (items_sent - start < budget) begin
         r = $urandom_range(99);
         if (r < 70) begin
            run_point($urandom_range(40), $urandom_range(9) == 0);
         end else if (r < 80) begin
            send_item(3'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST)), $urandom, $urandom,
                      $urandom, $urandom, $urandom);
         end else if (r < 88) begin
            send_item(CMD_FINISH, 0, 0, 0, 0, 0);
         end else begin
            // Broken sequence: a lone axis or neighbor, or an early re-center.
            send_item(3'($urandom_range(CMD_NEIGHBOR, CMD_CENTER)), near(1 << 18),
                      near(1 << 18), near(1 << 18), $urandom, $urandom);
         end
      end
   endtask

   initial begin
      reset = 1;
      csr_we = 0;
      csr_index = CSR_NBR_TARGET;
      csr_wdata = '0;
      req_ch.valid = 0;
      req_ch.command = CMD_CENTER;
      req_ch.vec_x = 0; req_ch.vec_y = 0; req_ch.vec_z = 0;
      req_ch.curv_major = 0; req_ch.curv_minor = 0;
      tx_fast = 0; rx_fast = 0; hold_req = 0;
      idle_cycles = 0; items_sent = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: finish straight after reset is skipped, unknown commands are dropped.
      send_item(CMD_FINISH, 0, 0, 0, 0, 0);
      send_item(CMD_RSVD_FIRST, 32'sh7FFFFFFF, -32'sh80000000, 0, 0, 0);
      send_item(CMD_RSVD_LAST, -1, -1, -1, -1, -1);
      // Zero axes make every abscissa zero, so the fit is singular.
      send_item(CMD_CENTER, 0, 0, 0, 0, 0);
      for (int i = 0; i < 16; i++)
         send_item(CMD_NEIGHBOR, i << 16, 0, 0, i << 14, -i << 14);
      send_item(CMD_FINISH, 0, 0, 0, 0, 0);
      // Unit axes, then two finishes over the sums already held.
      send_item(CMD_MAJOR, 32'sd65536, 0, 0, 0, 0);
      send_item(CMD_MINOR, 0, 32'sd65536, 0, 0, 0);
      send_item(CMD_FINISH, 0, 0, 0, 0, 0);
      send_item(CMD_FINISH, 0, 0, 0, 0, 0);
      // Extreme coordinates and curvatures.
      send_item(CMD_NEIGHBOR, 32'sh7FFFFFFF, -32'sh80000000, 32'sh7FFFFFFF,
                -32'sh80000000, 32'sh7FFFFFFF);
      send_item(CMD_FINISH, 0, 0, 0, 0, 0);

      // Full fit set: more than the fit limit of neighbors, negative slope.
      set_config(31'd2, 31'h7FFFFFFF, 31'd65535);
      run_point(40, 0);
      send_item(CMD_CENTER, 0, 0, 0, 0, 0);
      send_item(CMD_MAJOR, 32'sd65536, 0, 0, 0, 0);
      send_item(CMD_MINOR, 0, 32'sd65536, 0, 0, 0);
      for (int i = 0; i < 36; i++)
         send_item(CMD_NEIGHBOR, (i - 18) << 16, (i % 5) << 15, 0, -(i << 15), i << 13);
      send_item(CMD_FINISH, 0, 0, 0, 0, 0);

      // Random phases across register settings, extremes among them.
      set_config(31'd32, 31'd65536 << 4, 31'd256);
      run_random(150);
      set_config(31'd1, 31'h7FFFFFFF, 31'd65535);
      tx_fast = 1; rx_fast = 1;
      run_random(100);
      tx_fast = 0; rx_fast = 0;
      set_config(31'd256, 31'd0, 31'd1);
      run_random(60);
      set_config(31'd4, 31'h7FFFFFFF, 31'd256);
      // Receiver holds off while the sender keeps offering.
      hold_req = 1;
      tx_fast = 1;
      run_random(120);
      tx_fast = 0;
      // Sender waits for every response before going on.
      drain();
      for (int p = 0; p < 4; p++) begin
         set_config(31'($urandom_range(256, 1)), {3'($urandom_range(7)), 28'($urandom)},
                    31'($urandom_range(65535, 1)));
         run_random(110);
      end

      drain();
      $display("Sent %0d beats; %0d responses: %0d fitted, %0d skipped, %0d singular.",
               items_sent, sb.results_seen, sb.fits, sb.skips, sb.singulars);
      $display("Fitted responses with axis flip: %0d; mismatches: %0d.", sb.flips, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
